// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

	// result status codes
	localparam logic [2:0] ST_DATA    = 3'd0;
	localparam logic [2:0] ST_CLOSED  = 3'd1;
	localparam logic [2:0] ST_EOF     = 3'd2;
	localparam logic [2:0] ST_BADESC  = 3'd3;
	localparam logic [2:0] ST_NEWLINE = 3'd4;

	// characters the decoder looks for
	localparam logic [15:0] CH_QUOTE = 16'h0022;
	localparam logic [15:0] CH_BSLASH = 16'h005C;
	localparam logic [15:0] CH_SLASH = 16'h002F;
	localparam logic [15:0] CH_LF = 16'h000A;
	localparam logic [15:0] CH_CR = 16'h000D;
	localparam logic [15:0] CH_B = 16'h0062;
	localparam logic [15:0] CH_F = 16'h0066;
	localparam logic [15:0] CH_N = 16'h006E;
	localparam logic [15:0] CH_R = 16'h0072;
	localparam logic [15:0] CH_T = 16'h0074;
	localparam logic [15:0] CH_U = 16'h0075;

	// one output word without its last flag
	typedef struct packed {
		logic [15:0] ch;
		logic [2:0]  st;
	} res_t;

endpackage

// ===== rtl/json_string_unescape_utf8.sv =====
// channel   handshake            payload
// -------   ------------------   ------------------------------
// in        in_valid / in_stall  in_char[15:0], end_of_input
// out       out_valid/out_stall  out_char[15:0], status[2:0], last
// cfg       cfg_we               cfg_wdata (wide_chars)
//
// One input word is decoded per cycle, while in_stall is low, into a result buffer of three entries.
// Most words give zero or one result, and the next word is taken in the next cycle unless out_stall is high.
// The final hex digit of a \u escape in byte mode gives up to three bytes,
// which drain one per cycle while out_stall is low; input stalls until the last one is being taken.
// arst_n clears the phase, the hex digits, the buffer count and wide_chars.
// A stall on the output only holds the current result; the buffer keeps its words.
module json_string_unescape_utf8 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] in_char,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_char,
	output logic [2:0]  status,
	output logic        last
);

	// phase codes
	localparam logic [2:0] PH_PLAIN = 3'd0;
	localparam logic [2:0] PH_ESC   = 3'd1;
	localparam logic [2:0] PH_HEX1  = 3'd2;
	localparam logic [2:0] PH_HEX2  = 3'd3;
	localparam logic [2:0] PH_HEX3  = 3'd4;
	localparam logic [2:0] PH_HEX4  = 3'd5;

	logic              wide_q;
	logic [2:0]        phase_q;
	logic [11:0]       hex_q;
	jsu_pkg::res_t     buf_q [3];
	logic [1:0]        rd_q;
	logic [1:0]        rem_q;

	logic              in_acc;
	logic              out_acc;
	logic [15:0]       c;
	logic              is_hex;
	logic [3:0]        dig;
	logic [15:0]       code;
	logic [1:0]        n_d;
	jsu_pkg::res_t     r0_d, r1_d, r2_d;
	logic [2:0]        phase_d;
	logic [11:0]       hex_d;
	jsu_pkg::res_t     cur;

	// handshakes
	assign out_valid = (rem_q != 2'd0);
	assign out_acc   = out_valid && !out_stall;
	assign in_stall  = !((rem_q == 2'd0) || ((rem_q == 2'd1) && !out_stall));
	assign in_acc    = in_valid && !in_stall;

	// character as seen in the current mode
	assign c = wide_q ? in_char : {8'h00, in_char[7:0]};

	// hex digit decode
	always_comb begin
		is_hex = 1'b1;
		dig    = 4'd0;
		if ((c >= 16'h0030) && (c <= 16'h0039)) begin
			dig = c[3:0];
		end else if (((c >= 16'h0061) && (c <= 16'h0066)) ||
		             ((c >= 16'h0041) && (c <= 16'h0046))) begin
			dig = c[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
	end

	assign code = {hex_q, dig};

	// next state and results for the word on the input
	always_comb begin
		n_d     = 2'd0;
		r0_d    = '0;
		r1_d    = '0;
		r2_d    = '0;
		phase_d = phase_q;
		hex_d   = hex_q;
		if (end_of_input) begin
			n_d     = 2'd1;
			r0_d.st = jsu_pkg::ST_EOF;
			phase_d = PH_PLAIN;
			hex_d   = '0;
		end else begin
			unique case (phase_q) inside
				PH_ESC: begin
					phase_d = PH_PLAIN;
					n_d     = 2'd1;
					case (c) inside
						jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
							r0_d.ch = c;
						end
						jsu_pkg::CH_B: r0_d.ch = 16'h0008;
						jsu_pkg::CH_F: r0_d.ch = 16'h000C;
						jsu_pkg::CH_N: r0_d.ch = jsu_pkg::CH_LF;
						jsu_pkg::CH_R: r0_d.ch = jsu_pkg::CH_CR;
						jsu_pkg::CH_T: r0_d.ch = 16'h0009;
						jsu_pkg::CH_U: begin
							n_d     = 2'd0;
							phase_d = PH_HEX1;
							hex_d   = '0;
						end
						default: begin
							r0_d.st = jsu_pkg::ST_BADESC;
							hex_d   = '0;
						end
					endcase
				end
				PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
					if (!is_hex) begin
						n_d     = 2'd1;
						r0_d.st = jsu_pkg::ST_BADESC;
						phase_d = PH_PLAIN;
						hex_d   = '0;
					end else if (phase_q != PH_HEX4) begin
						phase_d = phase_q + 3'd1;
						hex_d   = {hex_q[7:0], dig};
					end else begin
						phase_d = PH_PLAIN;
						hex_d   = '0;
						if (code == 16'h0000) begin
							n_d     = 2'd1;
							r0_d.st = jsu_pkg::ST_BADESC;
						end else if (wide_q || (code < 16'h0080)) begin
							n_d     = 2'd1;
							r0_d.ch = code;
						end else if (code < 16'h0800) begin
							// two byte utf-8
							n_d     = 2'd2;
							r0_d.ch = {8'h00, 3'b110, code[10:6]};
							r1_d.ch = {8'h00, 2'b10, code[5:0]};
						end else begin
							// three byte utf-8
							n_d     = 2'd3;
							r0_d.ch = {8'h00, 4'b1110, code[15:12]};
							r1_d.ch = {8'h00, 2'b10, code[11:6]};
							r2_d.ch = {8'h00, 2'b10, code[5:0]};
						end
					end
				end
				default: begin
					// plain phase, unused codes fall here as well
					phase_d = PH_PLAIN;
					if (c == jsu_pkg::CH_QUOTE) begin
						n_d     = 2'd1;
						r0_d.st = jsu_pkg::ST_CLOSED;
						hex_d   = '0;
					end else if (c == jsu_pkg::CH_BSLASH) begin
						phase_d = PH_ESC;
					end else if ((c == jsu_pkg::CH_LF) || (c == jsu_pkg::CH_CR)) begin
						n_d     = 2'd1;
						r0_d.st = jsu_pkg::ST_NEWLINE;
						hex_d   = '0;
					end else begin
						n_d     = 2'd1;
						r0_d.ch = c;
					end
				end
			endcase
		end
	end

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
		end else if (cfg_we) begin
			wide_q <= cfg_wdata;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			hex_q   <= '0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			hex_q   <= hex_d;
		end
	end

	// result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 2'd0;
			rem_q <= 2'd0;
		end else if (in_acc) begin
			rd_q  <= 2'd0;
			rem_q <= n_d;
		end else if (out_acc) begin
			rd_q  <= rd_q + 2'd1;
			rem_q <= rem_q - 2'd1;
		end
	end

	// result buffer words
	always_ff @(posedge clk) begin
		if (in_acc && (n_d != 2'd0)) begin
			buf_q[0] <= r0_d;
			buf_q[1] <= r1_d;
			buf_q[2] <= r2_d;
		end
	end

	// output word select
	always_comb begin
		case (rd_q)
			2'd1:    cur = buf_q[1];
			2'd2:    cur = buf_q[2];
			default: cur = buf_q[0];
		endcase
	end

	assign out_char = cur.ch;
	assign status   = cur.st;
	assign last     = (rem_q == 2'd1);

	// a word is only taken when at most one result is left
	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (rem_q <= 2'd1))
		else $error("input taken while results still pending");

	// status results always end the burst
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != jsu_pkg::ST_DATA)) |-> last)
		else $error("status result not marked last");

	// status results carry no character
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != jsu_pkg::ST_DATA)) |-> (out_char == 16'h0000))
		else $error("status result with character");

	// draining a burst walks the buffer in order
	a_drain_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> (out_valid && (rd_q == $past(rd_q) + 2'd1)))
		else $error("burst drained out of order");

endmodule

// ===== test/json_string_unescape_utf8_test.sv =====
module json_string_unescape_utf8_test;

	// characters used to build hex digits and the decoded control escapes
	localparam logic [15:0] CH_DIGIT0  = 16'h0030;
	localparam logic [15:0] CH_UPPER_A = 16'h0041;
	localparam logic [15:0] CH_LOWER_A = 16'h0061;
	localparam logic [15:0] CH_LOWER_F = 16'h0066;
	localparam logic [15:0] CH_LOWER_G = 16'h0067;
	localparam logic [15:0] CH_LOWER_Q = 16'h0071;
	localparam logic [15:0] CH_UPPER_F = 16'h0046;
	localparam logic [15:0] CH_DIGIT9  = 16'h0039;
	localparam logic [15:0] CH_BS      = 16'h0008;
	localparam logic [15:0] CH_FF      = 16'h000C;
	localparam logic [15:0] CH_TAB     = 16'h0009;

	// utf-8 framing
	localparam logic [15:0] UTF8_LEAD2 = 16'h00C0;
	localparam logic [15:0] UTF8_LEAD3 = 16'h00E0;
	localparam logic [15:0] UTF8_CONT  = 16'h0080;
	localparam logic [15:0] UTF8_BITS  = 16'h003F;
	localparam logic [15:0] UTF8_TWO   = 16'h0080;
	localparam logic [15:0] UTF8_THREE = 16'h0800;

	typedef enum logic [2:0] {
		PH_PLAIN, PH_ESC, PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4
	} scan_t;

	typedef struct packed {
		logic [15:0] ch;
		logic        eoi;
	} in_word_t;

	typedef struct packed {
		jsu_pkg::res_t r;
		logic          last;
	} out_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] in_char = 16'h0000;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] out_char;
	logic [2:0]  status;
	logic        last;

	json_string_unescape_utf8 dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_char(in_char),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.status(status),
		.last(last)
	);

	always #1 clk = ~clk;

	// words waiting to be sent and decoded words waiting to arrive
	in_word_t  pending_words[$];
	out_word_t expected_words[$];

	// shadow of the decoder state
	logic        wide_mode = 1'b0;
	scan_t       scan_phase = PH_PLAIN;
	logic [15:0] hex_code = 16'h0000;

	int n_errors = 0;
	int n_words_taken = 0;
	int n_results_checked = 0;
	int n_settings = 1;

	task automatic push_result(input logic [15:0] ch, input logic [2:0] st, input logic fin);
		out_word_t w;
		w.r.ch = ch;
		w.r.st = st;
		w.last = fin;
		expected_words.push_back(w);
	endtask

	task automatic end_string(input logic [2:0] st);
		push_result(16'h0000, st, 1'b1);
		scan_phase = PH_PLAIN;
		hex_code = 16'h0000;
	endtask

	// escaped code point as utf-8 bytes or one wide character
	task automatic emit_code(input logic [15:0] code);
		if (wide_mode || code < UTF8_TWO) begin
			push_result(code, jsu_pkg::ST_DATA, 1'b1);
		end else if (code < UTF8_THREE) begin
			push_result(UTF8_LEAD2 | (code >> 6), jsu_pkg::ST_DATA, 1'b0);
			push_result(UTF8_CONT | (code & UTF8_BITS), jsu_pkg::ST_DATA, 1'b1);
		end else begin
			push_result(UTF8_LEAD3 | (code >> 12), jsu_pkg::ST_DATA, 1'b0);
			push_result(UTF8_CONT | ((code >> 6) & UTF8_BITS), jsu_pkg::ST_DATA, 1'b0);
			push_result(UTF8_CONT | (code & UTF8_BITS), jsu_pkg::ST_DATA, 1'b1);
		end
	endtask

	// bit 4 set when the character is a hex digit, value in the low bits
	function automatic logic [4:0] hex_nibble(input logic [15:0] c);
		if (c >= CH_DIGIT0 && c <= CH_DIGIT9)
			return {1'b1, 4'(c - CH_DIGIT0)};
		if (c >= CH_LOWER_A && c <= CH_LOWER_F)
			return {1'b1, 4'(c - CH_LOWER_A + 16'd10)};
		if (c >= CH_UPPER_A && c <= CH_UPPER_F)
			return {1'b1, 4'(c - CH_UPPER_A + 16'd10)};
		return 5'b00000;
	endfunction

	// expected results of one accepted word
	task automatic decode_word(input logic [15:0] raw, input logic eoi);
		logic [15:0] c;
		logic [4:0]  nib;
		c = wide_mode ? raw : {8'h00, raw[7:0]};
		if (eoi) begin
			end_string(jsu_pkg::ST_EOF);
		end else if (scan_phase == PH_ESC) begin
			scan_phase = PH_PLAIN;
			case (c) inside
				jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
					push_result(c, jsu_pkg::ST_DATA, 1'b1);
				jsu_pkg::CH_B: push_result(CH_BS, jsu_pkg::ST_DATA, 1'b1);
				jsu_pkg::CH_F: push_result(CH_FF, jsu_pkg::ST_DATA, 1'b1);
				jsu_pkg::CH_N: push_result(jsu_pkg::CH_LF, jsu_pkg::ST_DATA, 1'b1);
				jsu_pkg::CH_R: push_result(jsu_pkg::CH_CR, jsu_pkg::ST_DATA, 1'b1);
				jsu_pkg::CH_T: push_result(CH_TAB, jsu_pkg::ST_DATA, 1'b1);
				jsu_pkg::CH_U: begin
					scan_phase = PH_HEX1;
					hex_code = 16'h0000;
				end
				default: end_string(jsu_pkg::ST_BADESC);
			endcase
		end else if (scan_phase >= PH_HEX1 && scan_phase <= PH_HEX4) begin
			nib = hex_nibble(c);
			if (!nib[4]) begin
				end_string(jsu_pkg::ST_BADESC);
			end else begin
				hex_code = {hex_code[11:0], nib[3:0]};
				if (scan_phase != PH_HEX4) begin
					scan_phase = scan_t'(scan_phase + 3'd1);
				end else if (hex_code == 16'h0000) begin
					end_string(jsu_pkg::ST_BADESC);
				end else begin
					scan_phase = PH_PLAIN;
					emit_code(hex_code);
					hex_code = 16'h0000;
				end
			end
		end else begin
			scan_phase = PH_PLAIN;
			if (c == jsu_pkg::CH_QUOTE)
				end_string(jsu_pkg::ST_CLOSED);
			else if (c == jsu_pkg::CH_BSLASH)
				scan_phase = PH_ESC;
			else if (c == jsu_pkg::CH_LF || c == jsu_pkg::CH_CR)
				end_string(jsu_pkg::ST_NEWLINE);
			else
				push_result(c, jsu_pkg::ST_DATA, 1'b1);
		end
	endtask

	// sender: bursts of words with random gaps
	int       burst_left = 0;
	int       gap_left = 0;
	logic     took_word;
	logic     next_valid;
	in_word_t next_word;

	always @(posedge clk) begin
		took_word = in_valid && !in_stall;
		if (took_word) begin
			decode_word(in_char, end_of_input);
			n_words_taken++;
		end
		if (!in_valid || took_word) begin
			next_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_words.size() > 0) begin
				next_word = pending_words.pop_front();
				next_valid = 1'b1;
				in_char <= next_word.ch;
				end_of_input <= next_word.eoi;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end
			in_valid <= next_valid;
		end
	end

	// receiver: stall pattern changes whenever the low six bits of stall_tick come round to zero
	logic [7:0] stall_tick = 8'd0;
	int         stall_mode = 0;
	out_word_t  want;

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			n_results_checked++;
			if (expected_words.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected word char=%h status=%0d last=%0d",
					$time, out_char, status, last);
			end else begin
				want = expected_words.pop_front();
				if (out_char !== want.r.ch) begin
					n_errors++;
					$display("%0t: out_char expected %h actual %h", $time, want.r.ch, out_char);
				end
				if (status !== want.r.st) begin
					n_errors++;
					$display("%0t: status expected %0d actual %0d", $time, want.r.st, status);
				end
				if (last !== want.last) begin
					n_errors++;
					$display("%0t: last expected %0d actual %0d", $time, want.last, last);
				end
			end
		end
		stall_tick <= stall_tick + 8'd1;
		if (stall_tick[5:0] == 6'd0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			2: out_stall <= (stall_tick[2:0] >= 3'd5);
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	task automatic add_char(input logic [15:0] c);
		pending_words.push_back('{c, 1'b0});
	endtask

	task automatic add_end();
		pending_words.push_back('{16'($urandom_range(0, 16'hFFFF)), 1'b1});
	endtask

	// one hex digit in either case
	task automatic add_digit(input logic [3:0] nib);
		if (nib < 4'd10)
			add_char(CH_DIGIT0 + nib);
		else if ($urandom_range(0, 1))
			add_char(CH_UPPER_A + nib - 16'd10);
		else
			add_char(CH_LOWER_A + nib - 16'd10);
	endtask

	task automatic add_unicode(input logic [15:0] code);
		add_char(jsu_pkg::CH_BSLASH);
		add_char(jsu_pkg::CH_U);
		for (int i = 3; i >= 0; i--)
			add_digit(code[i*4 +: 4]);
	endtask

	function automatic logic [15:0] pick_code();
		case ($urandom_range(0, 9)) inside
			0: return 16'h0000;
			1, 2, 3: return 16'($urandom_range(1, 16'h007F));
			4, 5, 6: return 16'($urandom_range(16'h0080, 16'h07FF));
			default: return 16'($urandom_range(16'h0800, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [15:0] pick_simple_escape();
		case ($urandom_range(0, 7))
			0: return jsu_pkg::CH_QUOTE;
			1: return jsu_pkg::CH_BSLASH;
			2: return jsu_pkg::CH_SLASH;
			3: return jsu_pkg::CH_B;
			4: return jsu_pkg::CH_F;
			5: return jsu_pkg::CH_N;
			6: return jsu_pkg::CH_R;
			default: return jsu_pkg::CH_T;
		endcase
	endfunction

	// mostly well-formed string bodies, with some broken escapes and noise
	task automatic make_string();
		int n_parts;
		int kind;
		int n_digits;
		n_parts = $urandom_range(0, 8);
		for (int k = 0; k < n_parts; k++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				add_char(16'($urandom_range(0, 16'hFFFF)));
			end else if (kind < 60) begin
				add_char(jsu_pkg::CH_BSLASH);
				add_char(pick_simple_escape());
			end else if (kind < 86) begin
				add_unicode(pick_code());
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						add_char(jsu_pkg::CH_BSLASH);
						add_char(16'($urandom_range(0, 16'hFFFF)));
					end
					1: begin
						add_char(jsu_pkg::CH_BSLASH);
						add_char(jsu_pkg::CH_U);
						n_digits = $urandom_range(0, 3);
						for (int i = 0; i < n_digits; i++)
							add_digit(4'($urandom_range(0, 15)));
						add_char($urandom_range(0, 1) ? CH_LOWER_G
							: 16'($urandom_range(0, 16'hFFFF)));
					end
					2: add_char($urandom_range(0, 1) ? jsu_pkg::CH_LF : jsu_pkg::CH_CR);
					default: begin
						add_char(jsu_pkg::CH_BSLASH);
						if ($urandom_range(0, 1)) begin
							add_char(jsu_pkg::CH_U);
							n_digits = $urandom_range(0, 3);
							for (int i = 0; i < n_digits; i++)
								add_digit(4'($urandom_range(0, 15)));
						end
						add_end();
					end
				endcase
			end
		end
		kind = $urandom_range(0, 9);
		if (kind < 8)
			add_char(jsu_pkg::CH_QUOTE);
		else if (kind == 8)
			add_end();
	endtask

	// nothing queued, nothing in flight, then a settle wait
	task automatic wait_idle();
		while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_setting(input logic wide, input int n_words);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= wide;
		@(posedge clk);
		cfg_we <= 1'b0;
		wide_mode = wide;
		n_settings++;
		while (pending_words.size() < n_words)
			make_string();
		wait_idle();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part in byte mode straight after reset
		add_char(16'hAB41);
		add_unicode(16'h00E9);
		add_unicode(16'hFFFF);
		add_char(jsu_pkg::CH_BSLASH);
		add_char(CH_LOWER_Q);
		add_char(jsu_pkg::CH_LF);
		add_char(jsu_pkg::CH_BSLASH);
		add_char(jsu_pkg::CH_U);
		add_char(CH_DIGIT0);
		add_char(CH_LOWER_G);
		add_char(jsu_pkg::CH_QUOTE);
		add_end();
		wait_idle();

		// random strings under both modes
		run_setting(1'b1, 28);
		run_setting(1'b0, 28);
		run_setting(1'b1, 28);
		wait_idle();

		$display("decoded %0d input words into %0d checked results", n_words_taken,
			n_results_checked);
		$display("covered %0d mode settings, byte and wide", n_settings);
		if (n_errors == 0)
			$display("json_string_unescape_utf8_test passed");
		else
			$display("json_string_unescape_utf8_test failed");
		$finish;
	end

	// watchdog
	initial begin
		#400000;
		$display("json_string_unescape_utf8_test failed");
		$finish;
	end

endmodule
